// ----- rtl/est_pkg.sv -----
// Shared types and codes for the event subscription table.
// Used by est_cell and event_subscription_table; no dependencies.
`timescale 1ns / 1ps
package est_pkg;

   typedef logic [1:0] func_type;
   localparam func_type FN_SUBSCRIBE   = 2'd0;
   localparam func_type FN_UNSUBSCRIBE = 2'd1;
   localparam func_type FN_DISPATCH    = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE       = 2'd0;
   localparam status_type ST_LIST_FULL  = 2'd1;
   localparam status_type ST_TABLE_FULL = 2'd2;
   localparam status_type ST_NO_MODULE  = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_SEND
   } fsm_type;

   // Request token passed from cell to cell along the row chain.
   typedef struct packed {
      logic        valid;
      func_type    func;
      logic [15:0] event_id;
      logic [7:0]  module_id;
      logic        hit;
      logic        alloc;
      status_type  status;
   } token_type;

endpackage

// ----- rtl/event_subscription_table.sv -----
// Top level of the event subscription table: request FSM, row chain, result stage.
// Depends on est_pkg and est_cell.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_func, req_event_id, req_module_id
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_subscriber,
//           |           | rsp_has_subscriber, rsp_last
//
// One request at a time; it walks the row chain one row per cycle, and the results then
// follow one per cycle while rsp_ready is high.
// Subscribe without a module answers in the next cycle.
// Reset clears the row count and control; row contents need no reset.
// A stalled rsp holds the result and the next request waits for the last result.
`timescale 1ns / 1ps
module event_subscription_table
   import est_pkg::*;
#(
   parameter int MAX_EVENT_ROWS  = 16,
   parameter int MAX_SUBSCRIBERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_event_id,
   input  logic [7:0]  req_module_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_subscriber,
   output logic        rsp_has_subscriber,
   output logic        rsp_last
);

   localparam int RW = $clog2(MAX_EVENT_ROWS + 1);
   localparam int CW = $clog2(MAX_SUBSCRIBERS + 1);

   fsm_type                          state_ff, state_in;
   logic [RW-1:0]                    rows_ff, rows_in;
   token_type                        head_ff, head_in;
   status_type                       status_ff, status_in;
   logic                             has_ff, has_in;
   logic [MAX_SUBSCRIBERS-1:0][7:0]  list_ff, list_in;
   logic [CW-1:0]                    rem_ff, rem_in;

   token_type                        tok_chain   [MAX_EVENT_ROWS+1];
   logic [MAX_SUBSCRIBERS-1:0][7:0]  list_chain  [MAX_EVENT_ROWS+1];
   logic [CW-1:0]                    count_chain [MAX_EVENT_ROWS+1];
   token_type                        exit_tok;

   logic                             req_take;
   logic                             rsp_take;
   logic                             no_module;

   assign tok_chain[0]   = head_ff;
   assign list_chain[0]  = '0;
   assign count_chain[0] = '0;

   for (genvar r = 0; r < MAX_EVENT_ROWS; r++) begin : g_row
      est_cell #(
         .CELL_INDEX      (r),
         .MAX_EVENT_ROWS  (MAX_EVENT_ROWS),
         .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .rows_in_use (rows_ff),
         .tok_in      (tok_chain[r]),
         .list_in     (list_chain[r]),
         .count_in    (count_chain[r]),
         .tok_out     (tok_chain[r+1]),
         .list_out    (list_chain[r+1]),
         .count_out   (count_chain[r+1])
      );
   end

   assign exit_tok  = tok_chain[MAX_EVENT_ROWS];
   assign req_ready = (state_ff == FSM_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (state_ff == FSM_SEND);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign no_module = (req_func == FN_SUBSCRIBE) && (req_module_id == 8'd0);

   assign rsp_status         = status_ff;
   assign rsp_has_subscriber = has_ff;
   assign rsp_subscriber     = has_ff ? list_ff[0] : 8'd0;
   assign rsp_last           = !has_ff || (rem_ff == CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               state_in = no_module ? FSM_SEND : FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (exit_tok.valid) begin
               state_in = FSM_SEND;
            end
         end
         FSM_SEND: begin
            if (rsp_take && rsp_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      head_in   = '0;
      rows_in   = rows_ff;
      status_in = status_ff;
      has_in    = has_ff;
      list_in   = list_ff;
      rem_in    = rem_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               if (no_module) begin
                  status_in = ST_NO_MODULE;
                  has_in    = 1'b0;
               end else begin
                  head_in.valid     = 1'b1;
                  head_in.func      = req_func;
                  head_in.event_id  = req_event_id;
                  head_in.module_id = req_module_id;
                  head_in.status    = ST_DONE;
               end
            end
         end
         FSM_WALK: begin
            if (exit_tok.valid) begin
               rows_in = rows_ff + RW'(exit_tok.alloc);
               if (exit_tok.func == FN_SUBSCRIBE) begin
                  status_in = exit_tok.hit ? exit_tok.status : ST_TABLE_FULL;
               end else begin
                  status_in = ST_DONE;
               end
               has_in  = (exit_tok.func == FN_DISPATCH) && exit_tok.hit &&
                         (count_chain[MAX_EVENT_ROWS] != '0);
               list_in = list_chain[MAX_EVENT_ROWS];
               rem_in  = count_chain[MAX_EVENT_ROWS];
            end
         end
         FSM_SEND: begin
            if (rsp_take && !rsp_last) begin
               for (int j = 0; j < MAX_SUBSCRIBERS - 1; j++) begin
                  list_in[j] = list_ff[j+1];
               end
               rem_in = rem_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      has_ff    <= has_in;
      list_ff   <= list_in;
      rem_ff    <= rem_in;
      if (reset) begin
         state_ff <= FSM_IDLE;
         rows_ff  <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         head_ff  <= head_in;
      end
   end

`ifndef SYNTHESIS
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= RW'(MAX_EVENT_ROWS))
      else $error("row count beyond table size");

   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      exit_tok.valid |-> state_ff == FSM_WALK)
      else $error("request left the chain outside the walk");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != FSM_IDLE)
      else $error("accepted request did not start");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last |=> state_ff == FSM_IDLE)
      else $error("final result did not return to idle");

   a_rows_grow_one: assert property (@(posedge clock) disable iff (reset)
      rows_ff != $past(rows_ff) |-> rows_ff == $past(rows_ff) + RW'(1))
      else $error("row count jumped");
`endif

endmodule

// ----- rtl/est_cell.sv -----
// One table row: event id, subscriber count and ordered subscriber list.
// Acts on the request token as it passes; depends on est_pkg.
`timescale 1ns / 1ps
module est_cell
   import est_pkg::*;
#(
   parameter int CELL_INDEX      = 0,
   parameter int MAX_EVENT_ROWS  = 16,
   parameter int MAX_SUBSCRIBERS = 8,
   localparam int RW = $clog2(MAX_EVENT_ROWS + 1),
   localparam int CW = $clog2(MAX_SUBSCRIBERS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [RW-1:0]                    rows_in_use,
   input  token_type                        tok_in,
   input  logic [MAX_SUBSCRIBERS-1:0][7:0]  list_in,
   input  logic [CW-1:0]                    count_in,
   output token_type                        tok_out,
   output logic [MAX_SUBSCRIBERS-1:0][7:0]  list_out,
   output logic [CW-1:0]                    count_out
);

   logic [15:0]                      event_ff, event_in;
   logic [CW-1:0]                    count_ff, count_in_r;
   logic [MAX_SUBSCRIBERS-1:0][7:0]  list_ff, list_ff_in;
   token_type                        tok_out_ff, tok_out_in;
   logic [MAX_SUBSCRIBERS-1:0][7:0]  list_out_ff, list_out_in;
   logic [CW-1:0]                    count_out_ff, count_out_in;

   logic                             used;
   logic                             ev_match;
   logic [MAX_SUBSCRIBERS-1:0]       member;
   logic [MAX_SUBSCRIBERS-1:0]       shift;
   logic                             is_member;

   always_comb begin
      used     = rows_in_use > RW'(CELL_INDEX);
      ev_match = used && (event_ff == tok_in.event_id);
      for (int j = 0; j < MAX_SUBSCRIBERS; j++) begin
         member[j] = (CW'(j) < count_ff) && (list_ff[j] == tok_in.module_id);
      end
      shift[0] = member[0];
      for (int j = 1; j < MAX_SUBSCRIBERS; j++) begin
         shift[j] = shift[j-1] | member[j];
      end
      is_member = |member;
   end

   always_comb begin
      event_in     = event_ff;
      count_in_r   = count_ff;
      list_ff_in   = list_ff;
      tok_out_in   = tok_in;
      list_out_in  = list_in;
      count_out_in = count_in;
      if (tok_in.valid) begin
         case (tok_in.func)
            FN_SUBSCRIBE: begin
               if (!tok_in.hit && ev_match) begin
                  tok_out_in.hit = 1'b1;
                  if (is_member) begin
                     tok_out_in.status = ST_DONE;
                  end else if (count_ff >= CW'(MAX_SUBSCRIBERS)) begin
                     tok_out_in.status = ST_LIST_FULL;
                  end else begin
                     for (int j = 0; j < MAX_SUBSCRIBERS; j++) begin
                        if (CW'(j) == count_ff) begin
                           list_ff_in[j] = tok_in.module_id;
                        end
                     end
                     count_in_r        = count_ff + CW'(1);
                     tok_out_in.status = ST_DONE;
                  end
               end else if (!tok_in.hit && !used) begin
                  event_in          = tok_in.event_id;
                  list_ff_in[0]     = tok_in.module_id;
                  count_in_r        = CW'(1);
                  tok_out_in.hit    = 1'b1;
                  tok_out_in.alloc  = 1'b1;
                  tok_out_in.status = ST_DONE;
               end
            end
            FN_UNSUBSCRIBE: begin
               if (used && is_member) begin
                  for (int j = 0; j < MAX_SUBSCRIBERS - 1; j++) begin
                     if (shift[j]) begin
                        list_ff_in[j] = list_ff[j+1];
                     end
                  end
                  count_in_r = count_ff - CW'(1);
               end
            end
            FN_DISPATCH: begin
               if (!tok_in.hit && ev_match) begin
                  tok_out_in.hit = 1'b1;
                  list_out_in    = list_ff;
                  count_out_in   = count_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      event_ff     <= event_in;
      count_ff     <= count_in_r;
      list_ff      <= list_ff_in;
      list_out_ff  <= list_out_in;
      count_out_ff <= count_out_in;
      if (reset) begin
         tok_out_ff <= '0;
      end else begin
         tok_out_ff <= tok_out_in;
      end
   end

   assign tok_out   = tok_out_ff;
   assign list_out  = list_out_ff;
   assign count_out = count_out_ff;

endmodule
